FILE: design/tun_pkg.sv
package tun_pkg;

    // Output format of one normal component, Q1.15.
    localparam int NORM_W = 16;
    // Quotient bits produced by the divider, one per stage.
    localparam int QUO_W = 16;
    localparam logic [NORM_W-2:0] NORM_MAX = '1;

    typedef logic signed [NORM_W-1:0] norm_t;

    // One finished result item as it sits in the output queue.
    typedef struct packed {
        norm_t x;
        norm_t y;
        norm_t z;
        logic  deg;
    } result_t;

endpackage

FILE: design/triangle_unit_normal.sv
// Channel  Handshake           Payload
// s_       s_valid / s_ready   three vertices, nine signed COORD_WIDTH-bit coordinates
// m_       m_valid / m_ready   normal_x, normal_y, normal_z (Q1.15) and degenerate
//
// One item is accepted per cycle while the output queue has room.
// The pipeline is the front end (six stages), the square root (one stage per root bit)
// and the divider (one stage per quotient bit plus the output stage).
// Reset clears only valid bits, queue pointers and queue count; no clearing pass is needed.
// A stalled output fills a two-item queue; the whole pipeline then holds in place.
module triangle_unit_normal #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_first_x,
    input  logic signed [COORD_WIDTH-1:0] s_first_y,
    input  logic signed [COORD_WIDTH-1:0] s_first_z,
    input  logic signed [COORD_WIDTH-1:0] s_second_x,
    input  logic signed [COORD_WIDTH-1:0] s_second_y,
    input  logic signed [COORD_WIDTH-1:0] s_second_z,
    input  logic signed [COORD_WIDTH-1:0] s_third_x,
    input  logic signed [COORD_WIDTH-1:0] s_third_y,
    input  logic signed [COORD_WIDTH-1:0] s_third_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [15:0]            m_normal_x,
    output logic signed [15:0]            m_normal_y,
    output logic signed [15:0]            m_normal_z,
    output logic                          m_degenerate
);

    localparam int NW = 2 * COORD_WIDTH + 2;
    localparam int SW = 4 * COORD_WIDTH + 4;

    logic               en;
    logic               f_valid;
    logic [SW-1:0]      f_s;
    logic [2:0][NW-1:0] f_mag;
    logic [2:0]         f_neg;
    logic               f_deg;
    logic               r_valid;
    logic [NW-1:0]      r_root;
    logic [2:0][NW-1:0] r_mag;
    logic [2:0]         r_neg;
    logic               r_deg;
    logic               d_valid;
    tun_pkg::result_t   d_res;
    tun_pkg::result_t   m_res;

    assign s_ready = en;

    // Edges, cross product and squared length.
    tun_front #(.W(COORD_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .ax        (s_first_x),
        .ay        (s_first_y),
        .az        (s_first_z),
        .bx        (s_second_x),
        .by        (s_second_y),
        .bz        (s_second_z),
        .cx        (s_third_x),
        .cy        (s_third_y),
        .cz        (s_third_z),
        .out_valid (f_valid),
        .out_s     (f_s),
        .out_mag   (f_mag),
        .out_neg   (f_neg),
        .out_deg   (f_deg)
    );

    // Integer square root of the squared length.
    tun_sqrt #(.W(COORD_WIDTH)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_s      (f_s),
        .in_mag    (f_mag),
        .in_neg    (f_neg),
        .in_deg    (f_deg),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_mag   (r_mag),
        .out_neg   (r_neg),
        .out_deg   (r_deg)
    );

    // Component over length in Q1.15.
    tun_div #(.W(COORD_WIDTH)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_root   (r_root),
        .in_mag    (r_mag),
        .in_neg    (r_neg),
        .in_deg    (r_deg),
        .out_valid (d_valid),
        .out_res   (d_res)
    );

    // Output queue and pipeline advance.
    tun_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (d_valid),
        .in_res   (d_res),
        .en       (en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_normal_x   = m_res.x;
    assign m_normal_y   = m_res.y;
    assign m_normal_z   = m_res.z;
    assign m_degenerate = m_res.deg;

endmodule

FILE: design/tun_front.sv
module tun_front #(
    parameter int W = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [W-1:0]   ax,
    input  logic signed [W-1:0]   ay,
    input  logic signed [W-1:0]   az,
    input  logic signed [W-1:0]   bx,
    input  logic signed [W-1:0]   by,
    input  logic signed [W-1:0]   bz,
    input  logic signed [W-1:0]   cx,
    input  logic signed [W-1:0]   cy,
    input  logic signed [W-1:0]   cz,
    output logic                  out_valid,
    output logic [4*W+3:0]        out_s,
    output logic [2:0][2*W+1:0]   out_mag,
    output logic [2:0]            out_neg,
    output logic                  out_deg
);

    localparam int EW = W + 1;
    localparam int PW = 2 * EW;
    localparam int NW = 2 * W + 2;
    localparam int HW = W + 1;
    localparam int SW = 4 * W + 4;

    logic [5:0] v_reg;

    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [PW-1:0] p_reg  [6];

    logic [2:0][NW-1:0] mag3_reg, mag4_reg, mag5_reg, mag6_reg;
    logic [2:0]         neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic               deg4_reg, deg5_reg, deg6_reg;

    logic [2*HW-1:0] hh_reg [3];
    logic [2*HW-1:0] hl_reg [3];
    logic [2*HW-1:0] ll_reg [3];
    logic [SW-1:0]   sq_reg [3];
    logic [SW-1:0]   s_reg;

    logic signed [PW:0]  n_next [3];
    logic [2:0][NW-1:0]  mag_next;

    // Valid bits move with the data whenever the pipeline advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // Cross product components at full width and their magnitudes.
    always_comb begin
        n_next[0] = (PW+1)'(p_reg[0]) - (PW+1)'(p_reg[1]);
        n_next[1] = (PW+1)'(p_reg[2]) - (PW+1)'(p_reg[3]);
        n_next[2] = (PW+1)'(p_reg[4]) - (PW+1)'(p_reg[5]);
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = n_next[i][PW] ? NW'(-n_next[i]) : NW'(n_next[i]);
        end
    end

    // Payload stages: edges, products, components, partial squares, squares, sum.
    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg[0] <= EW'(bx) - EW'(ax);
            e1_reg[1] <= EW'(by) - EW'(ay);
            e1_reg[2] <= EW'(bz) - EW'(az);
            e2_reg[0] <= EW'(cx) - EW'(ax);
            e2_reg[1] <= EW'(cy) - EW'(ay);
            e2_reg[2] <= EW'(cz) - EW'(az);

            p_reg[0] <= PW'(e1_reg[1]) * PW'(e2_reg[2]);
            p_reg[1] <= PW'(e1_reg[2]) * PW'(e2_reg[1]);
            p_reg[2] <= PW'(e1_reg[2]) * PW'(e2_reg[0]);
            p_reg[3] <= PW'(e1_reg[0]) * PW'(e2_reg[2]);
            p_reg[4] <= PW'(e1_reg[0]) * PW'(e2_reg[1]);
            p_reg[5] <= PW'(e1_reg[1]) * PW'(e2_reg[0]);

            mag3_reg <= mag_next;
            neg3_reg <= {n_next[2][PW], n_next[1][PW], n_next[0][PW]};

            for (int i = 0; i < 3; i++) begin
                hh_reg[i] <= mag3_reg[i][NW-1:HW] * mag3_reg[i][NW-1:HW];
                hl_reg[i] <= mag3_reg[i][NW-1:HW] * mag3_reg[i][HW-1:0];
                ll_reg[i] <= mag3_reg[i][HW-1:0] * mag3_reg[i][HW-1:0];
            end
            mag4_reg <= mag3_reg;
            neg4_reg <= neg3_reg;
            deg4_reg <= (mag3_reg == '0);

            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= (SW'(hh_reg[i]) << (2 * HW)) + (SW'(hl_reg[i]) << (HW + 1))
                             + SW'(ll_reg[i]);
            end
            mag5_reg <= mag4_reg;
            neg5_reg <= neg4_reg;
            deg5_reg <= deg4_reg;

            s_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            mag6_reg <= mag5_reg;
            neg6_reg <= neg5_reg;
            deg6_reg <= deg5_reg;
        end
    end

    assign out_valid = v_reg[5];
    assign out_s     = s_reg;
    assign out_mag   = mag6_reg;
    assign out_neg   = neg6_reg;
    assign out_deg   = deg6_reg;

endmodule

FILE: design/tun_sqrt.sv
module tun_sqrt #(
    parameter int W = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [4*W+3:0]        in_s,
    input  logic [2:0][2*W+1:0]   in_mag,
    input  logic [2:0]            in_neg,
    input  logic                  in_deg,
    output logic                  out_valid,
    output logic [2*W+1:0]        out_root,
    output logic [2:0][2*W+1:0]   out_mag,
    output logic [2:0]            out_neg,
    output logic                  out_deg
);

    localparam int NW = 2 * W + 2;
    localparam int RW = 2 * W + 2;
    localparam int SW = 4 * W + 4;

    logic [RW-1:0]      v_reg;
    logic [RW+1:0]      rem_reg  [RW];
    logic [RW-1:0]      root_reg [RW];
    logic [SW-1:0]      s_reg    [RW];
    logic [2:0][NW-1:0] mag_reg  [RW];
    logic [2:0]         neg_reg  [RW];
    logic               deg_reg  [RW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[RW-2:0], in_valid};
        end
    end

    // One root bit per stage: bring down two radicand bits, try 4*root+1.
    for (genvar i = 0; i < RW; i++) begin : g_stage
        logic [RW+1:0]      rem_in;
        logic [RW-1:0]      root_in;
        logic [SW-1:0]      s_in;
        logic [2:0][NW-1:0] mag_in;
        logic [2:0]         neg_in;
        logic               deg_in;
        logic [RW+1:0]      rem_sh;
        logic [RW+1:0]      trial;
        logic               ge;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = in_s;
            assign mag_in  = in_mag;
            assign neg_in  = in_neg;
            assign deg_in  = in_deg;
        end else begin : g_next
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign s_in    = s_reg[i-1];
            assign mag_in  = mag_reg[i-1];
            assign neg_in  = neg_reg[i-1];
            assign deg_in  = deg_reg[i-1];
        end

        assign rem_sh = {rem_in[RW-1:0], s_in[SW-1:SW-2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_in[RW-2:0], ge};
                s_reg[i]    <= {s_in[SW-3:0], 2'b00};
                mag_reg[i]  <= mag_in;
                neg_reg[i]  <= neg_in;
                deg_reg[i]  <= deg_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_mag   = mag_reg[RW-1];
    assign out_neg   = neg_reg[RW-1];
    assign out_deg   = deg_reg[RW-1];

endmodule

FILE: design/tun_div.sv
module tun_div #(
    parameter int W = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*W+1:0]        in_root,
    input  logic [2:0][2*W+1:0]   in_mag,
    input  logic [2:0]            in_neg,
    input  logic                  in_deg,
    output logic                  out_valid,
    output tun_pkg::result_t      out_res
);

    localparam int RW = 2 * W + 2;
    localparam int QW = tun_pkg::QUO_W;

    logic [QW-1:0]         v_reg;
    logic [2:0][RW:0]      rem_reg  [QW];
    logic [2:0][QW-1:0]    q_reg    [QW];
    logic [RW-1:0]         root_reg [QW];
    logic [2:0]            neg_reg  [QW];
    logic                  deg_reg  [QW];

    logic                  vout_reg;
    tun_pkg::result_t      res_reg;
    tun_pkg::norm_t        comp_next [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg    <= '0;
            vout_reg <= 1'b0;
        end else if (en) begin
            v_reg    <= {v_reg[QW-2:0], in_valid};
            vout_reg <= v_reg[QW-1];
        end
    end

    // Restoring division of each magnitude by the root, one quotient bit a stage.
    // The magnitude never exceeds the root, so the first step needs no shift.
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [2:0][RW:0]   rem_in;
        logic [2:0][QW-1:0] q_in;
        logic [RW-1:0]      root_in;
        logic [2:0]         neg_in;
        logic               deg_in;
        logic [2:0][RW:0]   rem_sh;
        logic [2:0]         ge;

        if (k == 0) begin : g_first
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[j] = {1'b0, in_mag[j]};
                assign rem_sh[j] = rem_in[j];
            end
            assign q_in    = '0;
            assign root_in = in_root;
            assign neg_in  = in_neg;
            assign deg_in  = in_deg;
        end else begin : g_next
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[j] = rem_reg[k-1][j];
                assign rem_sh[j] = {rem_in[j][RW-1:0], 1'b0};
            end
            assign q_in    = q_reg[k-1];
            assign root_in = root_reg[k-1];
            assign neg_in  = neg_reg[k-1];
            assign deg_in  = deg_reg[k-1];
        end

        for (genvar j = 0; j < 3; j++) begin : g_cmp
            assign ge[j] = (rem_sh[j] >= {1'b0, root_in});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int j = 0; j < 3; j++) begin
                    rem_reg[k][j] <= ge[j] ? (rem_sh[j] - {1'b0, root_in}) : rem_sh[j];
                    q_reg[k][j]   <= {q_in[j][QW-2:0], ge[j]};
                end
                root_reg[k] <= root_in;
                neg_reg[k]  <= neg_in;
                deg_reg[k]  <= deg_in;
            end
        end
    end

    // Clamp the full-scale quotient, apply the sign, zero a degenerate face.
    always_comb begin
        logic [tun_pkg::NORM_W-2:0] m;
        for (int j = 0; j < 3; j++) begin
            m = q_reg[QW-1][j][QW-1] ? tun_pkg::NORM_MAX : q_reg[QW-1][j][QW-2:0];
            if (deg_reg[QW-1]) begin
                comp_next[j] = '0;
            end else if (neg_reg[QW-1][j]) begin
                comp_next[j] = -$signed({1'b0, m});
            end else begin
                comp_next[j] = $signed({1'b0, m});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.x   <= comp_next[0];
            res_reg.y   <= comp_next[1];
            res_reg.z   <= comp_next[2];
            res_reg.deg <= deg_reg[QW-1];
        end
    end

    assign out_valid = vout_reg;
    assign out_res   = res_reg;

endmodule

FILE: design/tun_outq.sv
module tun_outq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  tun_pkg::result_t  in_res,
    output logic              en,
    output logic              m_valid,
    input  logic              m_ready,
    output tun_pkg::result_t  m_res
);

    tun_pkg::result_t mem_reg [2];
    logic [1:0]       count_reg;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic             push;
    logic             pop;

    // The pipeline advances while the queue holds fewer than two items, so the
    // one item that can land in the same cycle always finds room.
    assign en      = (count_reg != 2'd2);
    assign push    = en && in_valid;
    assign m_valid = (count_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign m_res   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_res;
        end
    end

endmodule

FILE: design/tun_checker.sv
module tun_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_normal_x,
    input logic signed [15:0] m_normal_y,
    input logic signed [15:0] m_normal_z,
    input logic               m_degenerate
);

    // A degenerate face always carries a zero normal.
    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> (m_normal_x == 16'sd0) && (m_normal_y == 16'sd0)
                                    && (m_normal_z == 16'sd0))
        else $error("degenerate item with nonzero normal");

    // The clamp keeps every component off the most negative code.
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_x != -16'sd32768) && (m_normal_y != -16'sd32768)
                    && (m_normal_z != -16'sd32768))
        else $error("normal component outside +-32767");

    // A waiting result item holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_normal_x) && $stable(m_normal_y)
                                && $stable(m_normal_z) && $stable(m_degenerate))
        else $error("result item changed while stalled");

    // Reset empties the output queue.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (.*);
